[design/cba_pkg.sv]
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants of the chunked bump allocator
// Holds the payload word types, status codes, controller states and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  localparam int MAX_CHUNKS_DEF     = 16;
  localparam int MAX_ALIGN_LOG2_DEF = 16;

  localparam int BYTES_W  = 32;
  localparam int ALIGN_W  = 5;
  localparam int LG_W     = 6;   // holds a clamped alignment up to 32
  localparam int OFFSET_W = 48;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;

  localparam logic [OFFSET_W-1:0] INIT_CHUNK_SIZE = 48'd1048576;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_EXISTING = 2'd0,
    STATUS_NEW      = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [BYTES_W-1:0] request_bytes;
    logic [ALIGN_W-1:0] align_log2;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  chunk_index;
    logic [OFFSET_W-1:0] byte_offset;
  } result_t;

  typedef struct packed {
    logic load;     // latch a new request word
    logic capture;  // register the per-chunk fit vector
    logic commit;   // update the table and emit the result word
  } cmd_t;

endpackage

`default_nettype wire

[design/chunked_bump_allocator.sv]
// ----------------------------------------------------------------------------
// chunked_bump_allocator: bump allocation over a small table of chunks
// Places each request in the first open chunk with room at the requested
// alignment, or opens a new chunk of geometrically growing size.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  ------------------------------------
//   request   start / busy (accept on   request_bytes, align_log2
//             start && !busy)
//   result    done (one-cycle strobe)   status, chunk_index, byte_offset
//   config    cfg_write                 cfg_data (initial chunk size)
//
// A request runs as an evaluate step, in which every open chunk is tested in
// parallel and the fit vector is registered, and a commit step, in which the
// lowest fitting chunk is chosen and the table is written. The result word
// appears on the strobe in the cycle after the commit. A new request word is
// taken in the commit cycle itself, so back-to-back requests never wait in
// idle. Reset is synchronous and needs no clearing pass: only entries below
// the chunk count are ever examined. The receiver cannot stall.
//
`default_nettype none

module chunked_bump_allocator #(
  parameter int MAX_CHUNKS     = cba_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_ALIGN_LOG2 = cba_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request channel.
  input  wire logic                          start,
  output logic                               busy,
  input  wire cba_pkg::request_t             request,
  // Result channel.
  output logic                               done,
  output cba_pkg::result_t                   result,
  // Configuration: the initial chunk size, zero taken as one.
  input  wire logic                          cfg_write,
  input  wire logic [cba_pkg::OFFSET_W-1:0]  cfg_data
);

  // Commands from the sequencer to the table datapath.
  cba_pkg::cmd_t cmd;

  // The sequencer sets the rhythm; the datapath never stalls it.
  cba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the chunk table, the running chunk size and the
  // registered result word.
  cba_datapath #(
    .MAX_CHUNKS     (MAX_CHUNKS),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire

[design/cba_ctrl.sv]
// ----------------------------------------------------------------------------
// cba_ctrl: allocator sequencer
// Steps each request through an evaluate cycle and a commit cycle, and
// takes the next request during the commit cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output cba_pkg::cmd_t    cmd
);

  cba_pkg::state_t state;
  cba_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    cmd.load    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      cba_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cba_pkg::ST_EVAL;
        end
      end
      cba_pkg::ST_EVAL: begin
        busy        = 1'b1;
        cmd.capture = 1'b1;
        state_next  = cba_pkg::ST_UPDATE;
      end
      cba_pkg::ST_UPDATE: begin
        cmd.commit = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cba_pkg::ST_EVAL;
        end else begin
          state_next = cba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cba_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_capture_then_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.commit)
    else $error("evaluate cycle not followed by commit");
  a_commit_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(cmd.capture))
    else $error("commit without a preceding evaluate cycle");
`endif

endmodule

`default_nettype wire

[design/cba_datapath.sv]
// ----------------------------------------------------------------------------
// cba_datapath: chunk table and fit logic
// Holds the chunk table, the running chunk size and the request word, tests
// every open chunk in parallel and commits the chosen placement.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_datapath #(
  parameter int MAX_CHUNKS     = cba_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_ALIGN_LOG2 = cba_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire cba_pkg::cmd_t                   cmd,
  input  wire cba_pkg::request_t               request,
  input  wire logic                            cfg_write,
  input  wire logic [cba_pkg::OFFSET_W-1:0]    cfg_data,
  output logic                                 done,
  output cba_pkg::result_t                     result
);

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam int OW    = cba_pkg::OFFSET_W;
  localparam int AW    = OW + 1;   // aligned mark before the capacity test
  localparam int SW    = OW + 2;   // aligned mark plus request size

  logic [OW-1:0]                 used [MAX_CHUNKS];
  logic [OW-1:0]                 cap  [MAX_CHUNKS];
  logic [CNT_W-1:0]              chunk_count;
  logic [OW-1:0]                 next_size;
  logic [cba_pkg::BYTES_W-1:0]   req_bytes;
  logic [cba_pkg::LG_W-1:0]      req_lg;
  logic [MAX_CHUNKS-1:0]         fit_vec;

  logic [AW-1:0]                 align_mask;
  logic [AW-1:0]                 aligned [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0]         fit;
  logic [IDX_W-1:0]              sel_idx;
  logic                          hit;
  logic                          full;
  logic [IDX_W-1:0]              open_idx;
  logic [OW-1:0]                 new_cap;
  logic [OW-1:0]                 new_next;
  logic [OW-1:0]                 cfg_value;
  logic [cba_pkg::LG_W-1:0]      lg_clamped;

  assign align_mask = AW'((AW'(1) << req_lg) - AW'(1));

  // One lane per chunk: round the bump mark up and test the room left.
  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_lane
    assign aligned[i] = (AW'(used[i]) + align_mask) & ~align_mask;
    assign fit[i] = (CNT_W'(i) < chunk_count) &&
                    ((SW'(aligned[i]) + SW'(req_bytes)) <= SW'(cap[i]));
  end

  // Lowest registered fit wins.
  always_comb begin
    sel_idx = '0;
    hit     = 1'b0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (fit_vec[i]) begin
        sel_idx = IDX_W'(i);
        hit     = 1'b1;
      end
    end
  end

  assign full     = (chunk_count == CNT_W'(MAX_CHUNKS));
  assign open_idx = IDX_W'(chunk_count);
  assign new_cap  = (next_size > OW'(req_bytes)) ? next_size : OW'(req_bytes);
  assign new_next = new_cap[OW-1] ? {OW{1'b1}} : {new_cap[OW-2:0], 1'b0};
  assign cfg_value = (cfg_data == '0) ? OW'(1) : cfg_data;
  assign lg_clamped =
    (cba_pkg::LG_W'(request.align_log2) > cba_pkg::LG_W'(MAX_ALIGN_LOG2)) ?
    cba_pkg::LG_W'(MAX_ALIGN_LOG2) : cba_pkg::LG_W'(request.align_log2);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_count <= '0;
      next_size   <= cba_pkg::INIT_CHUNK_SIZE;
      done        <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cfg_write && (chunk_count == '0)) begin
        next_size <= cfg_value;
      end
      if (cmd.commit && !hit && !full) begin
        chunk_count <= chunk_count + CNT_W'(1);
        next_size   <= new_next;
      end
    end
  end

  // Payload: request word, fit vector, chunk table and result word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_bytes <= request.request_bytes;
      req_lg    <= lg_clamped;
    end
    if (cmd.capture) begin
      fit_vec <= fit;
    end
    if (cmd.commit) begin
      if (hit) begin
        used[sel_idx]      <= OW'(aligned[sel_idx] + AW'(req_bytes));
        result.status      <= cba_pkg::STATUS_EXISTING;
        result.chunk_index <= cba_pkg::INDEX_W'(sel_idx);
        result.byte_offset <= OW'(aligned[sel_idx]);
      end else if (full) begin
        result.status      <= cba_pkg::STATUS_FULL;
        result.chunk_index <= '0;
        result.byte_offset <= '0;
      end else begin
        used[open_idx]     <= OW'(req_bytes);
        cap[open_idx]      <= new_cap;
        result.status      <= cba_pkg::STATUS_NEW;
        result.chunk_index <= cba_pkg::INDEX_W'(open_idx);
        result.byte_offset <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_follows_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("commit did not produce a result word");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    chunk_count <= CNT_W'(MAX_CHUNKS))
    else $error("chunk count beyond table depth");
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == cba_pkg::STATUS_FULL) |-> full)
    else $error("table full reported with free entries");
`endif

endmodule

`default_nettype wire
